>>> design/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types, codes and defaults for the ARP resolver with cache aging.
// ----------------------------------------------------------------------------
package arpr_pkg;

    // default table sizes
    localparam int CACHE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int PARK_DEPTH_DEF      = 16;

    // field widths
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int HDL_W   = 16;
    localparam int AGE_W   = 16;
    localparam int KIND_W  = 2;
    localparam int OKIND_W = 3;
    localparam int CIDX_W  = 2;

    // input request kinds
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IPV4 = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

    // arp opcodes
    localparam logic [1:0] ARP_OP_REQ   = 2'd1;
    localparam logic [1:0] ARP_OP_REPLY = 2'd2;

    // result kinds
    localparam logic [OKIND_W-1:0] OUT_TX        = 3'd0;
    localparam logic [OKIND_W-1:0] OUT_ARP_REQ   = 3'd1;
    localparam logic [OKIND_W-1:0] OUT_ARP_REPLY = 3'd2;
    localparam logic [OKIND_W-1:0] OUT_DELIVER   = 3'd3;
    localparam logic [OKIND_W-1:0] OUT_DROP      = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_OWN_IP  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TTL     = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_RINT    = 2'd3;

    // configuration reset values
    localparam logic [AGE_W-1:0] TTL_RST  = 16'd30000;
    localparam logic [AGE_W-1:0] RINT_RST = 16'd5000;

    // table walk being performed
    typedef enum logic [2:0] {
        OP_SEND_CACHE,
        OP_SEND_PEND,
        OP_TICK_CACHE,
        OP_TICK_PEND,
        OP_LEARN,
        OP_RELEASE,
        OP_PCLEAR
    } t_op;

    // source of an emitted result
    typedef enum logic [2:0] {
        ESEL_TX_CACHE,
        ESEL_TX_REL,
        ESEL_DROP,
        ESEL_REQ,
        ESEL_DELIV,
        ESEL_REPLY
    } t_esel;

    // controller to datapath commands
    typedef struct packed {
        t_op   op;
        logic  load;
        logic  clr;
        logic  chk;
        logic  inc;
        logic  park_push;
        logic  lwrite;
        logic  pend_alloc;
        logic  kinit;
        logic  kskip;
        logic  rel_clear;
        logic  emit;
        t_esel esel;
        logic  flush;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic ours_ok;
        logic op_valid;
        logic is_req_me;
        logic match;
        logic last;
        logic park_full;
        logic req_needed;
        logic kzero;
        logic skip_stop;
        logic emit_ok;
        logic flush_done;
    } t_sts;

    // one result
    typedef struct packed {
        logic [OKIND_W-1:0] kind;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
        logic [HDL_W-1:0]   hdl;
    } t_res;

endpackage

>>> design/arpr_ram.sv
// ----------------------------------------------------------------------------
// arpr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module arpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/arpr_ctrl.sv
// ----------------------------------------------------------------------------
// arpr_ctrl
// Controller state machine: sequences the table walks of each request.
// ----------------------------------------------------------------------------
module arpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  arpr_pkg::t_sts i_sts,
    output arpr_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DISP  = 12'b0000_0000_0010,
        S_RD    = 12'b0000_0000_0100,
        S_CK    = 12'b0000_0000_1000,
        S_PARK  = 12'b0000_0001_0000,
        S_REQ   = 12'b0000_0010_0000,
        S_DELIV = 12'b0000_0100_0000,
        S_LWR   = 12'b0000_1000_0000,
        S_KINIT = 12'b0001_0000_0000,
        S_SKIP  = 12'b0010_0000_0000,
        S_REPLY = 12'b0100_0000_0000,
        S_FLUSH = 12'b1000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    arpr_pkg::t_op   r_op, n_op;
    arpr_pkg::t_cmd  cmd;

    // state and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= arpr_pkg::OP_SEND_CACHE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        cmd      = '0;
        cmd.op   = r_op;
        cmd.esel = arpr_pkg::ESEL_TX_CACHE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                cmd.clr = 1'b1;
                unique case (i_sts.kind)
                    arpr_pkg::KIND_SEND: begin
                        n_op    = arpr_pkg::OP_SEND_CACHE;
                        n_state = S_RD;
                    end
                    arpr_pkg::KIND_TICK: begin
                        n_op    = arpr_pkg::OP_TICK_CACHE;
                        n_state = S_RD;
                    end
                    arpr_pkg::KIND_IPV4: begin
                        n_state = i_sts.ours_ok ? S_DELIV : S_FLUSH;
                    end
                    default: begin
                        if (i_sts.ours_ok && i_sts.op_valid) begin
                            n_op    = arpr_pkg::OP_LEARN;
                            n_state = S_RD;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                endcase
            end
            S_RD: begin
                n_state = S_CK;
            end
            S_CK: begin
                unique case (r_op)
                    arpr_pkg::OP_SEND_CACHE: begin
                        if (i_sts.match) begin
                            cmd.emit = 1'b1;
                            cmd.esel = arpr_pkg::ESEL_TX_CACHE;
                            if (i_sts.emit_ok) n_state = S_FLUSH;
                        end else if (i_sts.last) begin
                            n_state = S_PARK;
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    arpr_pkg::OP_SEND_PEND: begin
                        cmd.chk = 1'b1;
                        if (i_sts.last) begin
                            n_state = S_REQ;
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    arpr_pkg::OP_TICK_CACHE: begin
                        cmd.chk = 1'b1;
                        if (i_sts.last) begin
                            cmd.clr = 1'b1;
                            n_op    = arpr_pkg::OP_TICK_PEND;
                        end else begin
                            cmd.inc = 1'b1;
                        end
                        n_state = S_RD;
                    end
                    arpr_pkg::OP_TICK_PEND: begin
                        cmd.chk = 1'b1;
                        if (i_sts.last) begin
                            n_state = S_FLUSH;
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    arpr_pkg::OP_LEARN: begin
                        cmd.chk = 1'b1;
                        if (i_sts.last) begin
                            n_state = S_LWR;
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    arpr_pkg::OP_RELEASE: begin
                        if (i_sts.match) begin
                            cmd.emit = 1'b1;
                            cmd.esel = arpr_pkg::ESEL_TX_REL;
                            if (i_sts.emit_ok) begin
                                cmd.rel_clear = 1'b1;
                                cmd.inc       = 1'b1;
                                n_state       = i_sts.last ? S_SKIP : S_RD;
                            end
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = i_sts.last ? S_SKIP : S_RD;
                        end
                    end
                    default: begin
                        cmd.chk = 1'b1;
                        if (i_sts.last) begin
                            n_state = S_REPLY;
                        end else begin
                            cmd.inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_PARK: begin
                if (i_sts.park_full) begin
                    cmd.emit = 1'b1;
                    cmd.esel = arpr_pkg::ESEL_DROP;
                    if (i_sts.emit_ok) begin
                        cmd.clr = 1'b1;
                        n_op    = arpr_pkg::OP_SEND_PEND;
                        n_state = S_RD;
                    end
                end else begin
                    cmd.park_push = 1'b1;
                    cmd.clr       = 1'b1;
                    n_op          = arpr_pkg::OP_SEND_PEND;
                    n_state       = S_RD;
                end
            end
            S_REQ: begin
                if (i_sts.req_needed) begin
                    cmd.emit = 1'b1;
                    cmd.esel = arpr_pkg::ESEL_REQ;
                    if (i_sts.emit_ok) begin
                        cmd.pend_alloc = 1'b1;
                        n_state        = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_DELIV: begin
                cmd.emit = 1'b1;
                cmd.esel = arpr_pkg::ESEL_DELIV;
                if (i_sts.emit_ok) n_state = S_FLUSH;
            end
            S_LWR: begin
                cmd.lwrite = 1'b1;
                n_state    = S_KINIT;
            end
            S_KINIT: begin
                cmd.kinit = 1'b1;
                if (i_sts.kzero) begin
                    n_state = S_SKIP;
                end else begin
                    n_op    = arpr_pkg::OP_RELEASE;
                    n_state = S_RD;
                end
            end
            S_SKIP: begin
                if (i_sts.skip_stop) begin
                    cmd.clr = 1'b1;
                    n_op    = arpr_pkg::OP_PCLEAR;
                    n_state = S_RD;
                end else begin
                    cmd.kskip = 1'b1;
                end
            end
            S_REPLY: begin
                if (i_sts.is_req_me) begin
                    cmd.emit = 1'b1;
                    cmd.esel = arpr_pkg::ESEL_REPLY;
                    if (i_sts.emit_ok) n_state = S_FLUSH;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            default: begin
                cmd.flush = 1'b1;
                if (i_sts.flush_done) n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

    // no result of an earlier request is left behind when a new one is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_sts.flush_done)
        else $error("result still held while idle");

endmodule

>>> design/arpr_dp.sv
// ----------------------------------------------------------------------------
// arpr_dp
// Datapath: request and configuration registers, cache, pending table and
// parking FIFO storage, walk counters and the result stage.
// ----------------------------------------------------------------------------
module arpr_dp #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int PARK_DEPTH      = arpr_pkg::PARK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  arpr_pkg::t_cmd               i_cmd,
    output arpr_pkg::t_sts               o_sts,
    // request fields
    input  logic [arpr_pkg::KIND_W-1:0]  i_kind,
    input  logic [arpr_pkg::IP_W-1:0]    i_next_hop_ip,
    input  logic [arpr_pkg::HDL_W-1:0]   i_datagram_handle,
    input  logic [arpr_pkg::MAC_W-1:0]   i_frame_dst_mac,
    input  logic                         i_parse_ok,
    input  logic [1:0]                   i_arp_opcode,
    input  logic [arpr_pkg::IP_W-1:0]    i_sender_ip,
    input  logic [arpr_pkg::MAC_W-1:0]   i_sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]    i_target_ip,
    input  logic [arpr_pkg::AGE_W-1:0]   i_elapsed_ms,
    // configuration
    input  logic                         i_cfg_valid,
    input  logic [arpr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]   i_cfg_data,
    // results
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [arpr_pkg::OKIND_W-1:0] o_out_kind,
    output logic [arpr_pkg::MAC_W-1:0]   o_dst_mac,
    output logic [arpr_pkg::IP_W-1:0]    o_arp_target_ip,
    output logic [arpr_pkg::HDL_W-1:0]   o_out_handle,
    output logic                         o_last
);

    localparam int C  = CACHE_ENTRIES;
    localparam int P  = PENDING_ENTRIES;
    localparam int K  = PARK_DEPTH;
    localparam int CW = $clog2(C);
    localparam int PW = (P > 1) ? $clog2(P) : 1;
    localparam int KW = $clog2(K);
    localparam int LW = $clog2(K + 1);
    localparam int IPW = arpr_pkg::IP_W;
    localparam int MW  = arpr_pkg::MAC_W;
    localparam int HW  = arpr_pkg::HDL_W;
    localparam int AGW = arpr_pkg::AGE_W;
    localparam int CWORD = IPW + MW + AGW;
    localparam int PWORD = IPW + AGW;
    localparam int KWORD = IPW + HW;

    // wrap-around increment of a parking FIFO pointer
    function automatic logic [KW-1:0] kinc(input logic [KW-1:0] x);
        kinc = (x == KW'(K - 1)) ? '0 : x + 1'b1;
    endfunction

    // saturating age update
    function automatic logic [AGW-1:0] age_add(input logic [AGW-1:0] a,
                                               input logic [AGW-1:0] d);
        logic [AGW:0] s;
        s = {1'b0, a} + {1'b0, d};
        age_add = s[AGW] ? '1 : s[AGW-1:0];
    endfunction

    // request registers
    logic [arpr_pkg::KIND_W-1:0] r_kind;
    logic [IPW-1:0]              r_hop, r_sip, r_tip;
    logic [HW-1:0]               r_hdl;
    logic [MW-1:0]               r_dmac, r_smac;
    logic                        r_pok;
    logic [1:0]                  r_aop;
    logic [AGW-1:0]              r_dms;

    // configuration registers
    logic [MW-1:0]  r_own_mac;
    logic [IPW-1:0] r_own_ip;
    logic [AGW-1:0] r_ttl, r_rint;

    // valid bits and FIFO pointers
    logic [C-1:0]  r_cvalid;
    logic [P-1:0]  r_pvalid;
    logic [K-1:0]  r_kvalid;
    logic [KW-1:0] r_head, r_tail;

    // walk counters and trackers
    logic [CW-1:0]  r_cidx, r_cm_idx, r_cf_idx, r_cmax_idx;
    logic           r_cm_f, r_cf_f;
    logic [AGW-1:0] r_cmax_age;
    logic [PW-1:0]  r_pidx, r_pf_idx;
    logic           r_pend_hit, r_pf_f;
    logic [KW-1:0]  r_kpos;
    logic [LW-1:0]  r_kcnt, r_klen;

    // result stage
    logic           r_hold_v, r_out_v, r_out_last;
    arpr_pkg::t_res r_hold, r_out;

    // storage ports
    logic             c_we, p_we;
    logic [CW-1:0]    c_waddr, slot;
    logic [PW-1:0]    p_waddr;
    logic [CWORD-1:0] c_wdata, c_rd;
    logic [PWORD-1:0] p_wdata, p_rd;
    logic [KWORD-1:0] k_rd;
    logic [IPW-1:0]   c_ip, p_ip, k_ip, key;
    logic [MW-1:0]    c_mac;
    logic [AGW-1:0]   c_age, p_age, c_age_n, p_age_n;
    logic [HW-1:0]    k_hdl;
    logic             c_exp, p_exp, c_match, p_match, k_match;
    logic [LW-1:0]    klen_c;
    logic             out_free, emit_ok, last, out_load;
    arpr_pkg::t_res   res;

    assign c_ip  = c_rd[CWORD-1 -: IPW];
    assign c_mac = c_rd[AGW +: MW];
    assign c_age = c_rd[AGW-1:0];
    assign p_ip  = p_rd[PWORD-1 -: IPW];
    assign p_age = p_rd[AGW-1:0];
    assign k_ip  = k_rd[KWORD-1 -: IPW];
    assign k_hdl = k_rd[HW-1:0];

    // aging of the entry under the walk
    assign c_age_n = age_add(c_age, r_dms);
    assign p_age_n = age_add(p_age, r_dms);
    assign c_exp   = (c_age_n >= r_ttl);
    assign p_exp   = (p_age_n >= r_rint);

    // address compares
    assign key = (i_cmd.op == arpr_pkg::OP_SEND_CACHE || i_cmd.op == arpr_pkg::OP_SEND_PEND)
                 ? r_hop : r_sip;
    assign c_match = r_cvalid[r_cidx] && (c_ip == key);
    assign p_match = r_pvalid[r_pidx] && (p_ip == key);
    assign k_match = r_kvalid[r_kpos] && (k_ip == r_sip);

    // replacement slot for a learned mapping
    assign slot = r_cm_f ? r_cm_idx : (r_cf_f ? r_cf_idx : r_cmax_idx);

    // parked occupancy from head to tail
    always_comb begin
        if (r_head == r_tail) begin
            klen_c = r_kvalid[r_head] ? LW'(K) : '0;
        end else if (r_tail > r_head) begin
            klen_c = LW'(r_tail) - LW'(r_head);
        end else begin
            klen_c = LW'(r_tail) + LW'(K) - LW'(r_head);
        end
    end

    // end of the current walk
    always_comb begin
        unique case (i_cmd.op)
            arpr_pkg::OP_SEND_CACHE,
            arpr_pkg::OP_TICK_CACHE,
            arpr_pkg::OP_LEARN:   last = (r_cidx == CW'(C - 1));
            arpr_pkg::OP_RELEASE: last = (r_kcnt == r_klen - 1'b1);
            default:              last = (r_pidx == PW'(P - 1));
        endcase
    end

    // cache storage
    assign c_we    = (i_cmd.chk && i_cmd.op == arpr_pkg::OP_TICK_CACHE && r_cvalid[r_cidx])
                     || i_cmd.lwrite;
    assign c_waddr = i_cmd.lwrite ? slot : r_cidx;
    assign c_wdata = i_cmd.lwrite ? {r_sip, r_smac, {AGW{1'b0}}} : {c_ip, c_mac, c_age_n};

    arpr_ram #(.WIDTH(CWORD), .DEPTH(C), .AW(CW)) u_cache (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_cidx),
        .o_rdata (c_rd)
    );

    // pending request storage
    assign p_we    = (i_cmd.chk && i_cmd.op == arpr_pkg::OP_TICK_PEND && r_pvalid[r_pidx])
                     || i_cmd.pend_alloc;
    assign p_waddr = i_cmd.pend_alloc ? r_pf_idx : r_pidx;
    assign p_wdata = i_cmd.pend_alloc ? {r_hop, {AGW{1'b0}}} : {p_ip, p_age_n};

    arpr_ram #(.WIDTH(PWORD), .DEPTH(P), .AW(PW)) u_pend (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_pidx),
        .o_rdata (p_rd)
    );

    // parking FIFO storage
    arpr_ram #(.WIDTH(KWORD), .DEPTH(K), .AW(KW)) u_park (
        .i_clk   (i_clk),
        .i_we    (i_cmd.park_push),
        .i_waddr (r_tail),
        .i_wdata ({r_hop, r_hdl}),
        .i_raddr (r_kpos),
        .o_rdata (k_rd)
    );

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_hop  <= i_next_hop_ip;
            r_hdl  <= i_datagram_handle;
            r_dmac <= i_frame_dst_mac;
            r_pok  <= i_parse_ok;
            r_aop  <= i_arp_opcode;
            r_sip  <= i_sender_ip;
            r_smac <= i_sender_mac;
            r_tip  <= i_target_ip;
            r_dms  <= i_elapsed_ms;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_ttl     <= arpr_pkg::TTL_RST;
            r_rint    <= arpr_pkg::RINT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                arpr_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                arpr_pkg::CFG_OWN_IP:  r_own_ip  <= i_cfg_data[IPW-1:0];
                arpr_pkg::CFG_TTL:     r_ttl     <= i_cfg_data[AGW-1:0];
                default:               r_rint    <= i_cfg_data[AGW-1:0];
            endcase
        end
    end

    // valid bits and FIFO pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_pvalid <= '0;
            r_kvalid <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            if (i_cmd.chk && i_cmd.op == arpr_pkg::OP_TICK_CACHE
                    && r_cvalid[r_cidx] && c_exp) begin
                r_cvalid[r_cidx] <= 1'b0;
            end
            if (i_cmd.lwrite) begin
                r_cvalid[slot] <= 1'b1;
            end
            if (i_cmd.chk && i_cmd.op == arpr_pkg::OP_TICK_PEND
                    && r_pvalid[r_pidx] && p_exp) begin
                r_pvalid[r_pidx] <= 1'b0;
            end
            if (i_cmd.chk && i_cmd.op == arpr_pkg::OP_PCLEAR && p_match) begin
                r_pvalid[r_pidx] <= 1'b0;
            end
            if (i_cmd.pend_alloc) begin
                r_pvalid[r_pf_idx] <= 1'b1;
            end
            if (i_cmd.park_push) begin
                r_kvalid[r_tail] <= 1'b1;
                r_tail           <= kinc(r_tail);
            end
            if (i_cmd.rel_clear) begin
                r_kvalid[r_kpos] <= 1'b0;
            end
            if (i_cmd.kskip) begin
                r_head <= kinc(r_head);
            end
        end
    end

    // walk counters and search trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_cidx     <= '0;
            r_pidx     <= '0;
            r_cm_f     <= 1'b0;
            r_cf_f     <= 1'b0;
            r_pend_hit <= 1'b0;
            r_pf_f     <= 1'b0;
        end else begin
            if (i_cmd.chk && i_cmd.op == arpr_pkg::OP_LEARN) begin
                if (c_match && !r_cm_f) begin
                    r_cm_f   <= 1'b1;
                    r_cm_idx <= r_cidx;
                end
                if (!r_cvalid[r_cidx] && !r_cf_f) begin
                    r_cf_f   <= 1'b1;
                    r_cf_idx <= r_cidx;
                end
                if (r_cidx == '0 || c_age > r_cmax_age) begin
                    r_cmax_idx <= r_cidx;
                    r_cmax_age <= c_age;
                end
            end
            if (i_cmd.chk && i_cmd.op == arpr_pkg::OP_SEND_PEND) begin
                if (p_match) r_pend_hit <= 1'b1;
                if (!r_pvalid[r_pidx] && !r_pf_f) begin
                    r_pf_f   <= 1'b1;
                    r_pf_idx <= r_pidx;
                end
            end
            if (i_cmd.inc) begin
                unique case (i_cmd.op)
                    arpr_pkg::OP_SEND_CACHE,
                    arpr_pkg::OP_TICK_CACHE,
                    arpr_pkg::OP_LEARN: r_cidx <= r_cidx + 1'b1;
                    arpr_pkg::OP_RELEASE: begin
                        r_kpos <= kinc(r_kpos);
                        r_kcnt <= r_kcnt + 1'b1;
                    end
                    default: r_pidx <= r_pidx + 1'b1;
                endcase
            end
        end
        if (i_cmd.kinit) begin
            r_kpos <= r_head;
            r_kcnt <= '0;
            r_klen <= klen_c;
        end
        if (i_cmd.kskip) begin
            r_klen <= r_klen - 1'b1;
        end
    end

    // result payload selection
    always_comb begin
        res      = '0;
        res.hdl  = r_hdl;
        unique case (i_cmd.esel)
            arpr_pkg::ESEL_TX_CACHE: begin
                res.kind = arpr_pkg::OUT_TX;
                res.mac  = c_mac;
            end
            arpr_pkg::ESEL_TX_REL: begin
                res.kind = arpr_pkg::OUT_TX;
                res.mac  = r_smac;
                res.hdl  = k_hdl;
            end
            arpr_pkg::ESEL_DROP: begin
                res.kind = arpr_pkg::OUT_DROP;
            end
            arpr_pkg::ESEL_REQ: begin
                res.kind = arpr_pkg::OUT_ARP_REQ;
                res.mac  = '1;
                res.ip   = r_hop;
                res.hdl  = '0;
            end
            arpr_pkg::ESEL_DELIV: begin
                res.kind = arpr_pkg::OUT_DELIVER;
            end
            default: begin
                res.kind = arpr_pkg::OUT_ARP_REPLY;
                res.mac  = r_smac;
                res.ip   = r_sip;
                res.hdl  = '0;
            end
        endcase
    end

    // hold stage keeps the newest result until the next one or the end
    assign out_free = !r_out_v || !i_stall;
    assign emit_ok  = !r_hold_v || out_free;
    assign out_load = (i_cmd.emit && emit_ok && r_hold_v)
                      || (!i_cmd.emit && i_cmd.flush && r_hold_v && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit && emit_ok) begin
                if (r_hold_v) begin
                    r_out      <= r_hold;
                    r_out_last <= 1'b0;
                end
                r_hold   <= res;
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush && r_hold_v && out_free) begin
                r_out      <= r_hold;
                r_out_last <= 1'b1;
                r_hold_v   <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_v;
    assign o_out_kind      = r_out.kind;
    assign o_dst_mac       = r_out.mac;
    assign o_arp_target_ip = r_out.ip;
    assign o_out_handle    = r_out.hdl;
    assign o_last          = r_out_last;

    // status back to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.kind       = r_kind;
        o_sts.ours_ok    = ((r_dmac == r_own_mac) || (r_dmac == '1)) && r_pok;
        o_sts.op_valid   = (r_aop == arpr_pkg::ARP_OP_REQ) || (r_aop == arpr_pkg::ARP_OP_REPLY);
        o_sts.is_req_me  = (r_aop == arpr_pkg::ARP_OP_REQ) && (r_tip == r_own_ip);
        o_sts.match      = (i_cmd.op == arpr_pkg::OP_RELEASE) ? k_match : c_match;
        o_sts.last       = last;
        o_sts.park_full  = r_kvalid[r_tail];
        o_sts.req_needed = !r_pend_hit && r_pf_f;
        o_sts.kzero      = (klen_c == '0);
        o_sts.skip_stop  = (r_klen == '0) || r_kvalid[r_head];
        o_sts.emit_ok    = emit_ok;
        o_sts.flush_done = !r_hold_v;
    end

    // a parked handle is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.park_push |-> !r_kvalid[r_tail])
        else $error("park push onto an occupied slot");

    // a new pending entry goes only into a free slot found by the walk
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pend_alloc |-> (r_pf_f && !r_pvalid[r_pf_idx]))
        else $error("pending allocation into a used slot");

    // release walk never spans more than the FIFO depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.kinit |=> (r_klen <= LW'(K)))
        else $error("parked length out of range");

endmodule

>>> design/arp_resolver_with_cache_aging_unit.sv
// Sequence: a send walks the cache entry by entry (registered RAM read), and on a miss
//   parks the handle and walks the pending table.
// A tick walks the cache, then the pending table; an ARP frame walks the cache,
//   the parked handles and the pending table; a dropped or IPv4 frame walks none.
// Throughput: one request at a time, the walk over the storage RAMs sets the rate.
// Reset: valid bits, FIFO pointers and configuration defaults load at once; no clearing pass.
// ----------------------------------------------------------------------------
// arp_resolver_with_cache_aging_unit
// ARP resolver with an aged IP-to-MAC cache, pending table and parking FIFO.
// ----------------------------------------------------------------------------
module arp_resolver_with_cache_aging_unit #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int PARK_DEPTH      = arpr_pkg::PARK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [arpr_pkg::KIND_W-1:0]  i_kind,
    input  logic [arpr_pkg::IP_W-1:0]    i_next_hop_ip,
    input  logic [arpr_pkg::HDL_W-1:0]   i_datagram_handle,
    input  logic [arpr_pkg::MAC_W-1:0]   i_frame_dst_mac,
    input  logic                         i_parse_ok,
    input  logic [1:0]                   i_arp_opcode,
    input  logic [arpr_pkg::IP_W-1:0]    i_sender_ip,
    input  logic [arpr_pkg::MAC_W-1:0]   i_sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]    i_target_ip,
    input  logic [arpr_pkg::AGE_W-1:0]   i_elapsed_ms,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [arpr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]   i_cfg_data,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [arpr_pkg::OKIND_W-1:0] o_out_kind,
    output logic [arpr_pkg::MAC_W-1:0]   o_dst_mac,
    output logic [arpr_pkg::IP_W-1:0]    o_arp_target_ip,
    output logic [arpr_pkg::HDL_W-1:0]   o_out_handle,
    output logic                         o_last
);

    arpr_pkg::t_cmd cmd;
    arpr_pkg::t_sts sts;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // controller
    arpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    arpr_dp #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .PARK_DEPTH      (PARK_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_kind            (i_kind),
        .i_next_hop_ip     (i_next_hop_ip),
        .i_datagram_handle (i_datagram_handle),
        .i_frame_dst_mac   (i_frame_dst_mac),
        .i_parse_ok        (i_parse_ok),
        .i_arp_opcode      (i_arp_opcode),
        .i_sender_ip       (i_sender_ip),
        .i_sender_mac      (i_sender_mac),
        .i_target_ip       (i_target_ip),
        .i_elapsed_ms      (i_elapsed_ms),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_kind        (o_out_kind),
        .o_dst_mac         (o_dst_mac),
        .o_arp_target_ip   (o_arp_target_ip),
        .o_out_handle      (o_out_handle),
        .o_last            (o_last)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ARP resolver: a directed table of requests followed by
// random send/ARP/IPv4/tick traffic in several idle and stall phases; every result
// is checked against a behavioral model of cache, pending table and park FIFO.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCACHE = arpr_pkg::CACHE_ENTRIES_DEF;
    localparam int NPEND  = arpr_pkg::PENDING_ENTRIES_DEF;
    localparam int NPARK  = arpr_pkg::PARK_DEPTH_DEF;
    localparam int MW     = arpr_pkg::MAC_W;
    localparam int IW     = arpr_pkg::IP_W;
    localparam int HW     = arpr_pkg::HDL_W;
    localparam int AW     = arpr_pkg::AGE_W;
    localparam int KW     = arpr_pkg::KIND_W;
    localparam int OKW    = arpr_pkg::OKIND_W;
    localparam logic [MW-1:0] BCAST = {MW{1'b1}};
    localparam int LIMIT_CYCLES = 900000;

    typedef struct {
        logic [KW-1:0] kind;
        logic [IW-1:0] nh;
        logic [HW-1:0] hdl;
        logic [MW-1:0] dmac;
        logic          pok;
        logic [1:0]    op;
        logic [IW-1:0] sip;
        logic [MW-1:0] smac;
        logic [IW-1:0] tip;
        logic [AW-1:0] ms;
    } t_req;

    typedef struct {
        logic [OKW-1:0] kind;
        logic [MW-1:0]  mac;
        logic [IW-1:0]  ip;
        logic [HW-1:0]  hdl;
        logic           last;
    } t_out;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_stall;
    logic [KW-1:0] i_kind = '0;
    logic [IW-1:0] i_next_hop_ip = '0, i_sender_ip = '0, i_target_ip = '0;
    logic [HW-1:0] i_datagram_handle = '0;
    logic [MW-1:0] i_frame_dst_mac = '0, i_sender_mac = '0;
    logic i_parse_ok = 0;
    logic [1:0] i_arp_opcode = '0;
    logic [AW-1:0] i_elapsed_ms = '0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [arpr_pkg::CIDX_W-1:0] i_cfg_index = '0;
    logic [MW-1:0] i_cfg_data = '0;
    logic o_valid, i_stall = 0;
    logic [OKW-1:0] o_out_kind;
    logic [MW-1:0] o_dst_mac;
    logic [IW-1:0] o_arp_target_ip;
    logic [HW-1:0] o_out_handle;
    logic o_last;

    arp_resolver_with_cache_aging_unit u_top (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // model state
    logic [MW-1:0] m_mac;
    logic [IW-1:0] m_ip;
    logic [AW-1:0] m_ttl, m_rint;
    logic [IW-1:0] c_ip [NCACHE];
    logic [MW-1:0] c_mac [NCACHE];
    logic [AW-1:0] c_age [NCACHE];
    bit            c_v [NCACHE];
    logic [IW-1:0] p_ip [NPEND];
    logic [AW-1:0] p_age [NPEND];
    bit            p_v [NPEND];
    logic [IW-1:0] k_ip [NPARK];
    logic [HW-1:0] k_hdl [NPARK];
    bit            k_v [NPARK];
    int k_head, k_tail;

    t_out pending_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0, stall_pct = 0;

    // ip pool keeps hits, misses and releases frequent
    logic [IW-1:0] ip_pool [8] = '{32'h0a000001, 32'h0a000002, 32'h0a000003,
        32'h0a000004, 32'hc0a80101, 32'hffffffff, 32'h00000000, 32'h7f000001};

    function automatic logic [AW-1:0] sat_add(logic [AW-1:0] a, logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[AW] ? {AW{1'b1}} : s[AW-1:0];
    endfunction

    function automatic void add_result(logic [OKW-1:0] k, logic [MW-1:0] mac,
                                       logic [IW-1:0] ip, logic [HW-1:0] h);
        t_out r;
        r.kind = k; r.mac = mac; r.ip = ip; r.hdl = h; r.last = 0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void learn_mapping(logic [IW-1:0] ip, logic [MW-1:0] mac);
        int slot;
        slot = -1;
        for (int i = 0; i < NCACHE; i++)
            if (slot < 0 && c_v[i] && c_ip[i] == ip) slot = i;
        for (int i = 0; i < NCACHE; i++)
            if (slot < 0 && !c_v[i]) slot = i;
        if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < NCACHE; i++)
                if (c_age[i] > c_age[slot]) slot = i;
        end
        c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = 0; c_v[slot] = 1;
    endfunction

    // expected results of one request, appended to pending_results
    function automatic void resolve_request(t_req q);
        int n0, free_slot, len, s;
        bit pend, ours;
        n0 = pending_results.size();
        ours = (q.dmac == m_mac) || (q.dmac == BCAST);
        if (q.kind == arpr_pkg::KIND_SEND) begin
            int hit;
            hit = -1;
            for (int i = 0; i < NCACHE; i++)
                if (hit < 0 && c_v[i] && c_ip[i] == q.nh) hit = i;
            if (hit >= 0) add_result(arpr_pkg::OUT_TX, c_mac[hit], '0, q.hdl);
            else begin
                if (k_v[k_tail]) add_result(arpr_pkg::OUT_DROP, '0, '0, q.hdl);
                else begin
                    k_ip[k_tail] = q.nh; k_hdl[k_tail] = q.hdl; k_v[k_tail] = 1;
                    k_tail = (k_tail + 1) % NPARK;
                end
                pend = 0; free_slot = -1;
                for (int i = 0; i < NPEND; i++) begin
                    if (p_v[i] && p_ip[i] == q.nh) pend = 1;
                    if (!p_v[i] && free_slot < 0) free_slot = i;
                end
                if (!pend && free_slot >= 0) begin
                    add_result(arpr_pkg::OUT_ARP_REQ, BCAST, q.nh, '0);
                    p_ip[free_slot] = q.nh; p_age[free_slot] = 0; p_v[free_slot] = 1;
                end
            end
        end else if (q.kind == arpr_pkg::KIND_TICK) begin
            for (int i = 0; i < NCACHE; i++)
                if (c_v[i]) begin
                    c_age[i] = sat_add(c_age[i], q.ms);
                    if (c_age[i] >= m_ttl) c_v[i] = 0;
                end
            for (int i = 0; i < NPEND; i++)
                if (p_v[i]) begin
                    p_age[i] = sat_add(p_age[i], q.ms);
                    if (p_age[i] >= m_rint) p_v[i] = 0;
                end
        end else if (ours && q.pok) begin
            if (q.kind == arpr_pkg::KIND_IPV4)
                add_result(arpr_pkg::OUT_DELIVER, '0, '0, q.hdl);
            else if (q.op == arpr_pkg::ARP_OP_REQ || q.op == arpr_pkg::ARP_OP_REPLY) begin
                learn_mapping(q.sip, q.smac);
                if (k_head == k_tail) len = k_v[k_head] ? NPARK : 0;
                else len = (k_tail + NPARK - k_head) % NPARK;
                for (int i = 0; i < len; i++) begin
                    s = (k_head + i) % NPARK;
                    if (k_v[s] && k_ip[s] == q.sip) begin
                        add_result(arpr_pkg::OUT_TX, q.smac, '0, k_hdl[s]);
                        k_v[s] = 0;
                    end
                end
                while (len > 0 && !k_v[k_head]) begin
                    k_head = (k_head + 1) % NPARK;
                    len--;
                end
                for (int i = 0; i < NPEND; i++)
                    if (p_v[i] && p_ip[i] == q.sip) p_v[i] = 0;
                if (q.op == arpr_pkg::ARP_OP_REQ && q.tip == m_ip)
                    add_result(arpr_pkg::OUT_ARP_REPLY, q.smac, q.sip, '0);
            end
        end
        if (pending_results.size() > n0)
            pending_results[pending_results.size()-1].last = 1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result kind %0d handle %h", $time,
                         o_out_kind, o_out_handle);
                errors <= errors + 1;
            end else begin
                t_out e;
                e = pending_results.pop_front();
                if (e.kind !== o_out_kind || e.mac !== o_dst_mac ||
                    e.ip !== o_arp_target_ip || e.hdl !== o_out_handle ||
                    e.last !== o_last) begin
                    $display("%0t mismatch exp kind %0d mac %h ip %h hdl %h last %b",
                             $time, e.kind, e.mac, e.ip, e.hdl, e.last);
                    $display("%0t          got kind %0d mac %h ip %h hdl %h last %b",
                             $time, o_out_kind, o_dst_mac, o_arp_target_ip,
                             o_out_handle, o_last);
                    errors <= errors + 1;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    // timeout
    always @(posedge i_clk)
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end

    task automatic write_reg(logic [arpr_pkg::CIDX_W-1:0] idx, logic [MW-1:0] val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            arpr_pkg::CFG_OWN_MAC: m_mac = val;
            arpr_pkg::CFG_OWN_IP:  m_ip = val[IW-1:0];
            arpr_pkg::CFG_TTL:     m_ttl = val[AW-1:0];
            default:               m_rint = val[AW-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // drive one request; result expectations are built at acceptance
    task automatic send_request(t_req q);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1; i_kind <= q.kind; i_next_hop_ip <= q.nh;
        i_datagram_handle <= q.hdl; i_frame_dst_mac <= q.dmac; i_parse_ok <= q.pok;
        i_arp_opcode <= q.op; i_sender_ip <= q.sip; i_sender_mac <= q.smac;
        i_target_ip <= q.tip; i_elapsed_ms <= q.ms;
        do @(posedge i_clk); while (o_stall);
        resolve_request(q);
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [KW-1:0] k, logic [IW-1:0] nh,
            logic [HW-1:0] h, logic [MW-1:0] dm, logic pk, logic [1:0] op,
            logic [IW-1:0] sip, logic [MW-1:0] sm, logic [IW-1:0] tip,
            logic [AW-1:0] ms);
        t_req q;
        q.kind = k; q.nh = nh; q.hdl = h; q.dmac = dm; q.pok = pk; q.op = op;
        q.sip = sip; q.smac = sm; q.tip = tip; q.ms = ms;
        return q;
    endfunction

    function automatic t_req rand_request();
        t_req q;
        int r;
        q = mk(arpr_pkg::KIND_SEND, ip_pool[$urandom_range(7)], HW'($urandom), BCAST,
               1'b1, 2'($urandom_range(1, 2)), ip_pool[$urandom_range(7)],
               MW'({$urandom, $urandom}), ip_pool[$urandom_range(7)],
               AW'($urandom_range(0, 3000)));
        r = $urandom_range(99);
        if (r < 45) q.kind = arpr_pkg::KIND_SEND;
        else if (r < 75) q.kind = arpr_pkg::KIND_ARP;
        else if (r < 85) q.kind = arpr_pkg::KIND_IPV4;
        else q.kind = arpr_pkg::KIND_TICK;
        if (q.kind != arpr_pkg::KIND_SEND) begin
            // mostly our own or broadcast frames, some noise
            r = $urandom_range(9);
            if (r < 4) q.dmac = m_mac;
            else if (r == 9) q.dmac = MW'({$urandom, $urandom});
            q.pok = ($urandom_range(9) != 0);
            if ($urandom_range(9) == 0) q.op = 2'($urandom);
            if ($urandom_range(3) == 0) q.tip = m_ip;
        end
        if ($urandom_range(19) == 0) begin
            q.nh = $urandom; q.sip = $urandom; q.ms = AW'($urandom);
        end
        return q;
    endfunction

    t_req dir_tab [$];

    initial begin
        t_req q;
        m_mac = '0; m_ip = '0; m_ttl = arpr_pkg::TTL_RST; m_rint = arpr_pkg::RINT_RST;
        foreach (c_v[i]) c_v[i] = 0;
        foreach (p_v[i]) p_v[i] = 0;
        foreach (k_v[i]) k_v[i] = 0;
        k_head = 0; k_tail = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults after reset, then extremes and special cases
        dir_tab = '{
            mk(arpr_pkg::KIND_SEND, 32'h0a000001, 16'h0000, '0, '0, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_SEND, 32'h0a000001, 16'hffff, '0, '0, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_IPV4, '0, 16'h1234, '0, 1'b1, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_IPV4, '0, 16'h1235, BCAST, '0, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_ARP, '0, '0, BCAST, 1'b1, '0, 32'h0a000001, 48'h1, '0, '0),
            mk(arpr_pkg::KIND_ARP, '0, '0, BCAST, 1'b1, 2'd3, 32'h0a000001, 48'h1, '0, '0),
            mk(arpr_pkg::KIND_ARP, '0, '0, BCAST, 1'b1, arpr_pkg::ARP_OP_REPLY,
               32'h0a000001, 48'haaaa_bbbb_cccc, '0, '0),
            mk(arpr_pkg::KIND_SEND, 32'h0a000001, 16'h0042, '0, '0, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_ARP, '0, '0, 48'h0, 1'b1, arpr_pkg::ARP_OP_REQ, 32'hffffffff,
               BCAST, 32'h0, '0),
            mk(arpr_pkg::KIND_ARP, '0, '0, 48'h5, 1'b1, arpr_pkg::ARP_OP_REQ, 32'h2,
               48'h2, 32'h0, '0),
            mk(arpr_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 16'hffff),
            mk(arpr_pkg::KIND_SEND, 32'h0a000001, 16'h0043, '0, '0, '0, '0, '0, '0, '0),
            mk(arpr_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 16'h0000)
        };
        foreach (dir_tab[i]) send_request(dir_tab[i]);
        drain();

        // fill the park FIFO and pending table, forcing drops and suppression
        for (int i = 0; i < 20; i++)
            send_request(mk(arpr_pkg::KIND_SEND, 32'h0b000000 + IW'(i % 10), HW'(i),
                            '0, '0, '0, '0, '0, '0, '0));
        // fill the cache so the oldest gets replaced
        for (int i = 0; i < 18; i++) begin
            send_request(mk(arpr_pkg::KIND_ARP, '0, '0, BCAST, 1'b1, arpr_pkg::ARP_OP_REPLY,
                            32'h0b000000 + IW'(i), 48'h100 + MW'(i), '0, '0));
            if (i % 4 == 0)
                send_request(mk(arpr_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0, '0, '0,
                                16'd7));
        end
        drain();

        // random phases through several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                3: begin send_idle_pct = 25; stall_pct = 25; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            write_reg(arpr_pkg::CFG_OWN_MAC,
                      ph == 4 ? BCAST - 1'b1 : MW'({$urandom, $urandom}));
            write_reg(arpr_pkg::CFG_OWN_IP, MW'(ip_pool[$urandom_range(7)]));
            write_reg(arpr_pkg::CFG_TTL, ph == 0 ? MW'(1) : ph == 1 ? MW'(16'hffff)
                                         : MW'($urandom_range(500, 9000)));
            write_reg(arpr_pkg::CFG_RINT, ph == 0 ? MW'(16'hffff) : ph == 1 ? MW'(1)
                                          : MW'($urandom_range(300, 6000)));
            for (int i = 0; i < 45; i++) begin
                q = rand_request();
                send_request(q);
            end
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> arp_resolver_with_cache_aging_unit.f
design/arpr_pkg.sv
design/arpr_ram.sv
design/arpr_ctrl.sv
design/arpr_dp.sv
design/arp_resolver_with_cache_aging_unit.sv
dv/tb_top.sv
